// ===== design/assert_macros.svh =====
// Assertion helpers; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// prop must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// cond must never be true out of reset
`define ASSERT_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

// ===== design/smt_pkg.sv =====
package smt_pkg;

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 2;
	localparam int M_TDATA_W = 40;
	localparam int CFG_W     = 16;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// transaction kinds
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_CMD   = 2'd2;

	// register indexes
	localparam logic REG_HALF = 1'b0;
	localparam logic REG_GAP  = 1'b1;

	localparam logic [7:0]  CMD_PREFIX = 8'h01;
	localparam logic [15:0] HALF_RESET = 16'd50;
	localparam logic [15:0] GAP_RESET  = 16'd1000;

	localparam logic [3:0] OUT_BITS_ONE = 4'd7;
	localparam logic [3:0] OUT_BITS_TWO = 4'd15;
	localparam logic [5:0] READ_BITS_M1 = 6'd7;
	localparam logic [5:0] GAP_BIT      = 6'd8;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_OUT_LO = 7'b0000010,
		PH_OUT_HI = 7'b0000100,
		PH_GAP    = 7'b0001000,
		PH_IN_LO  = 7'b0010000,
		PH_IN_HI  = 7'b0100000,
		PH_DONE   = 7'b1000000
	} phase_t;

	// one classified tick as queued between front and sequencer
	typedef struct packed {
		logic        start;
		logic [1:0]  op;
		logic [15:0] shift;
		logic [3:0]  bits_m1;
		logic        miso;
	} q_entry_t;

	// one result tick, packed lowest field last
	typedef struct packed {
		logic [31:0] response;
		logic        done_res;
		logic        busy_res;
		logic        cs_n;
		logic        mosi;
		logic        sclk;
	} res_t;

endpackage

// ===== design/spi_master_transactions_core.sv =====
// An accepted tick enters the tick queue; its result is registered on m_tdata when dequeued.
// Throughput: one tick per cycle, s_tready drops only when the four-entry tick queue is full.
// A stalled m_tready backs up into the queue; the sequencer steps once per dequeued tick.
// Reset (arst_n low, asynchronous): queue empty, sequencer idle, no result pending;
// half_period_ticks returns to 50 and byte_gap_ticks to 1000.
// SPI mode 0, MSB first; bit and gap timing counts ticks, not clock cycles.
module spi_master_transactions_core
	import smt_pkg::*;
#(
	parameter int RESPONSE_BYTES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// tick requests
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [0] start_req, [8:1] address, [16:9] value, [17] miso, rest zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	// [1:0] kind
	input  logic [S_TUSER_W-1:0] s_tuser,
	// pin results
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [0] sclk, [1] mosi, [2] cs_n, [3] busy_res, [4] done_res, [36:5] response, rest zero
	output logic [M_TDATA_W-1:0] m_tdata,
	// register writes: 0 half_period_ticks, 1 byte_gap_ticks
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	// front end: decode kind and preload the outgoing shift word per request
	q_entry_t f_entry;
	logic     f_push;
	logic     q_full;

	// queue toward the pin sequencer
	q_entry_t q_entry;
	logic     q_empty;
	logic     q_pop;

	smt_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_full   (q_full),
		.push     (f_push),
		.entry    (f_entry)
	);

	smt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.din    (f_entry),
		.full   (q_full),
		.pop    (q_pop),
		.dout   (q_entry),
		.empty  (q_empty)
	);

	// back end: phase machine, tick and bit counters, output register
	smt_seq #(
		.RESPONSE_BYTES (RESPONSE_BYTES)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (!q_empty),
		.in_entry  (q_entry),
		.pop       (q_pop),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// ===== design/smt_front.sv =====
module smt_front
	import smt_pkg::*;
(
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,
	input  logic [S_TUSER_W-1:0] s_tuser,
	input  logic                 q_full,
	output logic                 push,
	output q_entry_t             entry
);

	logic [7:0] address;
	logic [7:0] value;

	assign address  = s_tdata[8:1];
	assign value    = s_tdata[16:9];
	assign s_tready = !q_full;
	assign push     = s_tvalid && !q_full;

	always_comb begin
		entry.start = s_tdata[0];
		entry.miso  = s_tdata[17];
		unique case (s_tuser)
			OP_WRITE: begin
				entry.op      = OP_WRITE;
				entry.shift   = {address, value};
				entry.bits_m1 = OUT_BITS_TWO;
			end
			OP_READ: begin
				entry.op      = OP_READ;
				entry.shift   = {address, 8'h00};
				entry.bits_m1 = OUT_BITS_ONE;
			end
			default: begin
				// command, also the unused fourth kind
				entry.op      = OP_CMD;
				entry.shift   = {CMD_PREFIX, address};
				entry.bits_m1 = OUT_BITS_TWO;
			end
		endcase
	end

endmodule

// ===== design/smt_fifo.sv =====
module smt_fifo
	import smt_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t din,
	output logic     full,
	input  logic     pop,
	output q_entry_t dout,
	output logic     empty
);

	q_entry_t          mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign dout  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== design/smt_seq.sv =====
`include "assert_macros.svh"
module smt_seq
	import smt_pkg::*;
#(
	parameter int RESPONSE_BYTES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  q_entry_t             in_entry,
	output logic                 pop,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata
);

	localparam int         IN_BITS    = RESPONSE_BYTES * 8;
	localparam logic [5:0] IN_BITS_M1 = 6'(IN_BITS - 1);

	logic [15:0] half_q;
	logic [15:0] gap_q;

	phase_t      phase_q, ph_n;
	logic [1:0]  op_q, op_n;
	logic [15:0] tc_q, tc_n;
	logic [5:0]  bc_q, bc_n;
	logic [15:0] os_q, os_n;
	logic [31:0] ins_q, ins_n;
	logic        mosi_q;

	res_t        res;
	res_t        out_q;
	logic        out_valid_q;

	logic [15:0] half_len;
	logic [15:0] gap_len;
	logic [15:0] tc_inc;

	assign half_len = (half_q == '0) ? 16'd1 : half_q;
	assign gap_len  = (gap_q == '0) ? 16'd1 : gap_q;

	assign pop      = in_valid && (!out_valid_q || m_tready);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_TDATA_W - $bits(res_t)){1'b0}}, out_q};

	always_comb begin
		ph_n   = phase_q;
		op_n   = op_q;
		tc_n   = tc_q;
		bc_n   = bc_q;
		os_n   = os_q;
		ins_n  = ins_q;
		res    = '0;
		res.cs_n     = 1'b1;
		res.busy_res = 1'b1;

		if (phase_q == PH_IDLE && in_entry.start) begin
			op_n  = in_entry.op;
			tc_n  = '0;
			ins_n = '0;
			ph_n  = PH_OUT_LO;
			os_n  = in_entry.shift;
			bc_n  = {2'b00, in_entry.bits_m1};
		end

		tc_inc = tc_n + 16'd1;

		unique case (ph_n)
			PH_IDLE: begin
				res.busy_res = 1'b0;
			end
			PH_DONE: begin
				res.busy_res = 1'b0;
				res.done_res = 1'b1;
				res.response = ins_n;
				ph_n         = PH_IDLE;
			end
			PH_OUT_LO: begin
				res.cs_n = 1'b0;
				res.mosi = os_n[15];
				if (tc_inc >= half_len) begin
					tc_n = '0;
					ph_n = PH_OUT_HI;
				end else begin
					tc_n = tc_inc;
				end
			end
			PH_OUT_HI: begin
				res.cs_n = 1'b0;
				res.sclk = 1'b1;
				res.mosi = os_n[15];
				if (tc_inc >= half_len) begin
					tc_n = '0;
					os_n = {os_n[14:0], 1'b0};
					if (bc_n == '0) begin
						if (op_n == OP_WRITE) begin
							ph_n = PH_DONE;
						end else begin
							bc_n = (op_n == OP_READ) ? READ_BITS_M1 : IN_BITS_M1;
							ph_n = PH_IN_LO;
						end
					end else begin
						if (op_n == OP_WRITE && bc_n == GAP_BIT && gap_q != '0) begin
							ph_n = PH_GAP;
						end else begin
							ph_n = PH_OUT_LO;
						end
						bc_n = bc_n - 6'd1;
					end
				end else begin
					tc_n = tc_inc;
				end
			end
			PH_GAP: begin
				// hold the last address bit on the data line
				res.cs_n = 1'b0;
				res.mosi = mosi_q;
				if (tc_inc >= gap_len) begin
					tc_n = '0;
					ph_n = PH_OUT_LO;
				end else begin
					tc_n = tc_inc;
				end
			end
			PH_IN_LO: begin
				res.cs_n = 1'b0;
				if (tc_inc >= half_len) begin
					tc_n = '0;
					ph_n = PH_IN_HI;
				end else begin
					tc_n = tc_inc;
				end
			end
			PH_IN_HI: begin
				res.cs_n = 1'b0;
				res.sclk = 1'b1;
				if (tc_inc >= half_len) begin
					tc_n  = '0;
					ins_n = {ins_n[30:0], in_entry.miso};
					if (bc_n == '0) begin
						ph_n = PH_DONE;
					end else begin
						bc_n = bc_n - 6'd1;
						ph_n = PH_IN_LO;
					end
				end else begin
					tc_n = tc_inc;
				end
			end
			default: begin
				ph_n         = PH_IDLE;
				res.busy_res = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= HALF_RESET;
			gap_q  <= GAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF: half_q <= cfg_data;
				REG_GAP:  gap_q  <= cfg_data;
				default:  ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			op_q        <= OP_WRITE;
			tc_q        <= '0;
			bc_q        <= '0;
			os_q        <= '0;
			ins_q       <= '0;
			mosi_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				phase_q <= ph_n;
				op_q    <= op_n;
				tc_q    <= tc_n;
				bc_q    <= bc_n;
				os_q    <= os_n;
				ins_q   <= ins_n;
				mosi_q  <= res.mosi;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	`ASSERT_ALWAYS(a_done_to_idle, (pop && phase_q == PH_DONE) |=> phase_q == PH_IDLE, "no idle after done")
	`ASSERT_ALWAYS(a_hold_no_pop, !pop |=> $stable({phase_q, tc_q, bc_q}), "step without tick")
	`ASSERT_NEVER(a_idle_cs_high, m_tvalid && !out_q.busy_res && !out_q.cs_n, "cs_n low while idle")

endmodule

// ===== bench/tb_spi_master_transactions_core.sv =====
`timescale 1ns / 1ps

// Each request is one timing tick of the SPI master.
// The bench predicts the pin levels, status flags and response for every accepted tick, lines the expected results up
// in order, and checks every result beat against the oldest one.
module tb_spi_master_transactions_core;
	import smt_pkg::*;

	localparam int RESP_BYTES  = 4;
	localparam int IN_BITS     = (RESP_BYTES * 8 > 64) ? 64 : RESP_BYTES * 8;
	localparam int HOLD_CYCLES = 60;    // long receiver hold-off, fills the tick queue
	localparam int STALL_LIMIT = 2000;  // cycles without any handshake before giving up

	typedef enum int {MISO_LOW, MISO_HIGH, MISO_RANDOM} miso_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata;
	logic [S_TUSER_W-1:0] s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_we;
	logic                 cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	spi_master_transactions_core #(
		.RESPONSE_BYTES(RESP_BYTES)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// ---------------------------------------------------------------------------------------
	// Pin sequencer prediction: own copy of the registers and of the sequencer state.
	// ---------------------------------------------------------------------------------------
	logic [15:0] half_cfg;
	logic [15:0] gap_cfg;
	logic [1:0]  mdl_op;
	phase_t      mdl_phase;
	logic [15:0] mdl_ticks;
	logic [5:0]  mdl_bits;
	logic [15:0] mdl_out;
	logic [31:0] mdl_in;
	logic        mdl_sclk;
	logic        mdl_mosi;
	logic        mdl_csn;

	res_t pins_expected[$];  // predicted result per accepted tick, oldest first
	int   errors;

	// sender / receiver pacing
	bit tx_fast;
	bit rx_fast;
	bit hold_ask;
	int rx_wait;
	int quiet;

	task automatic reset_model();
		half_cfg  = HALF_RESET;
		gap_cfg   = GAP_RESET;
		mdl_op    = OP_WRITE;
		mdl_phase = PH_IDLE;
		mdl_ticks = '0;
		mdl_bits  = '0;
		mdl_out   = '0;
		mdl_in    = '0;
		mdl_sclk  = 1'b0;
		mdl_mosi  = 1'b0;
		mdl_csn   = 1'b1;
	endtask

	// one tick of a phase of len ticks; true when the phase is over
	function automatic bit count_tick(input logic [15:0] len);
		mdl_ticks = mdl_ticks + 16'd1;
		if (mdl_ticks >= len) begin
			mdl_ticks = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic res_t predict_pins(input logic start, input logic [1:0] kind,
		input logic [7:0] addr, input logic [7:0] val, input logic miso);
		logic [15:0] half;
		logic        held_mosi;
		res_t        r;
		half      = (half_cfg == '0) ? 16'd1 : half_cfg;
		held_mosi = mdl_mosi;
		r         = '0;
		r.busy_res = 1'b1;

		// a start accepted in idle is already the first low-phase tick
		if (mdl_phase == PH_IDLE && start) begin
			mdl_op    = (kind > OP_CMD) ? OP_CMD : kind;
			mdl_ticks = '0;
			mdl_in    = '0;
			mdl_phase = PH_OUT_LO;
			case (mdl_op)
				OP_WRITE: begin
					mdl_out  = {addr, val};
					mdl_bits = 6'd15;
				end
				OP_READ: begin
					mdl_out  = {addr, 8'h00};
					mdl_bits = 6'd7;
				end
				default: begin
					mdl_out  = {CMD_PREFIX, addr};
					mdl_bits = 6'd15;
				end
			endcase
		end

		case (mdl_phase)
			PH_IDLE: begin
				{mdl_sclk, mdl_mosi, mdl_csn} = 3'b001;
				r.busy_res = 1'b0;
			end
			PH_DONE: begin
				{mdl_sclk, mdl_mosi, mdl_csn} = 3'b001;
				r.busy_res = 1'b0;
				r.done_res = 1'b1;
				r.response = mdl_in;
				mdl_phase  = PH_IDLE;
			end
			PH_OUT_LO: begin
				{mdl_sclk, mdl_mosi, mdl_csn} = {1'b0, mdl_out[15], 1'b0};
				if (count_tick(half)) mdl_phase = PH_OUT_HI;
			end
			PH_OUT_HI: begin
				{mdl_sclk, mdl_mosi, mdl_csn} = {1'b1, mdl_out[15], 1'b0};
				if (count_tick(half)) begin
					mdl_out = mdl_out << 1;
					if (mdl_bits == '0) begin
						if (mdl_op == OP_WRITE) begin
							mdl_phase = PH_DONE;
						end else begin
							mdl_bits  = (mdl_op == OP_READ) ? 6'd7 : 6'(IN_BITS - 1);
							mdl_phase = PH_IN_LO;
						end
					end else begin
						// gap only between the address and value bytes of a write
						if (mdl_op == OP_WRITE && mdl_bits == 6'd8 && gap_cfg != '0)
							mdl_phase = PH_GAP;
						else
							mdl_phase = PH_OUT_LO;
						mdl_bits = mdl_bits - 6'd1;
					end
				end
			end
			PH_GAP: begin
				// mosi keeps the last address bit
				{mdl_sclk, mdl_mosi, mdl_csn} = {1'b0, held_mosi, 1'b0};
				if (count_tick((gap_cfg == '0) ? 16'd1 : gap_cfg)) mdl_phase = PH_OUT_LO;
			end
			PH_IN_LO: begin
				{mdl_sclk, mdl_mosi, mdl_csn} = 3'b000;
				if (count_tick(half)) mdl_phase = PH_IN_HI;
			end
			PH_IN_HI: begin
				{mdl_sclk, mdl_mosi, mdl_csn} = 3'b100;
				if (count_tick(half)) begin
					mdl_in = {mdl_in[30:0], miso};
					if (mdl_bits == '0) begin
						mdl_phase = PH_DONE;
					end else begin
						mdl_bits  = mdl_bits - 6'd1;
						mdl_phase = PH_IN_LO;
					end
				end
			end
			default: begin
				{mdl_sclk, mdl_mosi, mdl_csn} = 3'b001;
				r.busy_res = 1'b0;
				mdl_phase  = PH_IDLE;
			end
		endcase

		r.sclk = mdl_sclk;
		r.mosi = mdl_mosi;
		r.cs_n = mdl_csn;
		return r;
	endfunction

	// ---------------------------------------------------------------------------------------
	// Clock
	// ---------------------------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ---------------------------------------------------------------------------------------
	// Sender side. Entered and left at a rising edge; s_tvalid stays high on return so that
	// back-to-back requests never drop valid for a step.
	// ---------------------------------------------------------------------------------------
	task automatic send_tick(input logic start, input logic [1:0] kind,
		input logic [7:0] addr, input logic [7:0] val, input logic miso);
		int idle_n;
		idle_n = tx_fast ? 0 : $urandom_range(0, 8);
		if (idle_n > 0) begin
			s_tvalid <= 1'b0;
			repeat (idle_n) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= S_TDATA_W'({miso, val, addr, start});
		s_tuser  <= kind;
		do @(posedge clk); while (!s_tready);
		pins_expected.push_back(predict_pins(start, kind, addr, val, miso));
	endtask

	// mostly well-formed: starts when idle, only the odd stray start while busy
	task automatic send_random_tick();
		logic start;
		if (mdl_phase == PH_IDLE)
			start = ($urandom_range(0, 3) != 0);
		else
			start = ($urandom_range(0, 15) == 0);
		send_tick(start, 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), 1'($urandom));
	endtask

	// ticks until the running transaction has passed its done tick;
	// poke puts a start on every busy tick and on the done tick, all of which must be ignored
	task automatic finish_txn(input miso_mode_t mode, input bit poke);
		logic m;
		while (mdl_phase != PH_IDLE) begin
			m = (mode == MISO_RANDOM) ? 1'($urandom) : (mode == MISO_HIGH);
			send_tick(poke, 2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom), m);
		end
	endtask

	task automatic run_txn(input logic [1:0] kind, input logic [7:0] addr,
		input logic [7:0] val, input miso_mode_t mode, input bit poke);
		send_tick(1'b1, kind, addr, val, 1'b0);
		finish_txn(mode, poke);
	endtask

	// stop offering requests and wait until every predicted result is back
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pins_expected.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_reg(input logic idx, input logic [15:0] data);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_HALF)
			half_cfg = data;
		else
			gap_cfg = data;
	endtask

	// ---------------------------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------------------------

	// idle pins after reset, reset half period, half period changed mid-transaction
	task automatic test_reset_state();
		repeat (4) send_tick(1'b0, OP_WRITE, 8'h00, 8'h00, 1'($urandom));
		send_tick(1'b1, OP_READ, 8'hFF, 8'hFF, 1'b1);
		repeat (60) send_tick(1'b0, OP_READ, 8'h00, 8'h00, 1'b1);  // sclk rises at tick 50
		set_reg(REG_HALF, 16'hFFFF);
		repeat (10) send_tick(1'b0, OP_READ, 8'h00, 8'h00, 1'b1);
		set_reg(REG_HALF, 16'd1);  // count already past the new length: phase ends next tick
		finish_txn(MISO_HIGH, 1'b0);
	endtask

	// reset gap, gap level, gap changed while in the gap
	task automatic test_write_gap();
		send_tick(1'b1, OP_WRITE, 8'h00, 8'hFF, 1'b0);
		while (mdl_phase != PH_GAP) send_tick(1'b0, OP_WRITE, 8'h00, 8'h00, 1'($urandom));
		repeat (20) send_tick(1'b0, OP_WRITE, 8'h00, 8'h00, 1'($urandom));
		set_reg(REG_GAP, 16'hFFFF);
		repeat (5) send_tick(1'b0, OP_WRITE, 8'h00, 8'h00, 1'($urandom));
		set_reg(REG_GAP, 16'd3);
		finish_txn(MISO_RANDOM, 1'b0);
		run_txn(OP_WRITE, 8'hFF, 8'h00, MISO_RANDOM, 1'b0);
	endtask

	// zero half period and zero gap, every kind, requests while busy and on the done tick
	task automatic test_zero_settings();
		set_reg(REG_HALF, 16'd0);
		set_reg(REG_GAP, 16'd0);
		run_txn(OP_WRITE, 8'hA5, 8'h5A, MISO_RANDOM, 1'b1);
		run_txn(OP_READ, 8'h3C, 8'hFF, MISO_HIGH, 1'b0);
		run_txn(OP_READ, 8'hC3, 8'h00, MISO_LOW, 1'b1);
		run_txn(OP_CMD, 8'hFF, 8'h00, MISO_RANDOM, 1'b1);
		run_txn(2'd3, 8'h00, 8'hFF, MISO_HIGH, 1'b0);  // kind three runs as a command
		// start right on the tick after a done tick
		run_txn(OP_READ, 8'h81, 8'h7E, MISO_RANDOM, 1'b0);
	endtask

	task automatic test_random_traffic(input int n, input logic [15:0] half,
		input logic [15:0] gap, input bit fast);
		set_reg(REG_HALF, half);
		set_reg(REG_GAP, gap);
		tx_fast = fast;
		rx_fast = fast;
		repeat (n) send_random_tick();
		settle();  // sender pauses until everything predicted has arrived
		tx_fast = 1'b0;
		rx_fast = 1'b0;
	endtask

	// receiver holds off while the sender keeps offering: queue fills, s_tready drops
	task automatic test_backpressure();
		set_reg(REG_HALF, 16'd1);
		set_reg(REG_GAP, 16'd2);
		tx_fast  = 1'b1;
		rx_fast  = 1'b0;
		hold_ask = 1'b1;
		repeat (50) send_random_tick();
		settle();
		tx_fast = 1'b0;
	endtask

	// ---------------------------------------------------------------------------------------
	// Receiver: random stall before each result outside fast runs, plus one long hold-off.
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (m_tvalid && m_tready) rx_wait = rx_fast ? 0 : $urandom_range(0, 8);
		if (hold_ask) begin
			rx_wait  = HOLD_CYCLES;
			hold_ask = 1'b0;
		end
		if (rx_wait > 0) begin
			m_tready <= 1'b0;
			rx_wait--;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------------------------------
	task automatic compare_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = res_t'(m_tdata[$bits(res_t)-1:0]);
			if (pins_expected.size() == 0) begin
				errors++;
				$display("%0t: result with nothing expected, expected none, got %h",
					$time, m_tdata);
			end else begin
				want = pins_expected.pop_front();
				compare_field("sclk", want.sclk, got.sclk);
				compare_field("mosi", want.mosi, got.mosi);
				compare_field("cs_n", want.cs_n, got.cs_n);
				compare_field("busy_res", want.busy_res, got.busy_res);
				compare_field("done_res", want.done_res, got.done_res);
				compare_field("response", want.response, got.response);
				compare_field("padding", 32'd0, 32'(m_tdata >> $bits(res_t)));
			end
		end
	end

	// ---------------------------------------------------------------------------------------
	// Watchdog: no handshake on either side for too long ends the run
	// ---------------------------------------------------------------------------------------
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet);
			$display("tb_spi_master_transactions_core: done, errors");
			$finish;
		end
	end

	// ---------------------------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------------------------
	initial begin
		errors   = 0;
		quiet    = 0;
		rx_wait  = 0;
		tx_fast  = 1'b0;
		rx_fast  = 1'b0;
		hold_ask = 1'b0;
		reset_model();
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		m_tready  <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_HALF;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_write_gap();
		test_zero_settings();
		test_random_traffic(40, 16'd1, 16'd0, 1'b0);
		test_backpressure();
		test_random_traffic(40, 16'd1, 16'd7, 1'b0);
		test_random_traffic(30, 16'd3, 16'd1, 1'b1);
		test_random_traffic(30, 16'd0, 16'd1, 1'b0);

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb_spi_master_transactions_core: done, clean");
		else
			$display("tb_spi_master_transactions_core: done, errors");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+design
design/smt_pkg.sv
design/smt_front.sv
design/smt_fifo.sv
design/smt_seq.sv
design/spi_master_transactions_core.sv
bench/tb_spi_master_transactions_core.sv
